### design/rv32_pkg.sv
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants of the RV32IM subset execute core
// Controller states, the command/status structs between controller and
// datapath, and the instruction encodings of the supported subset.
// ----------------------------------------------------------------------------
package rv32_pkg;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MEM,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_item;
		logic rf_read;
		logic exec;
		logic mem_step;
		logic div_step;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic go_mem;
		logic go_div;
		logic mem_last;
		logic div_last;
		logic out_busy;
	} dp_stat_t;

	// Result status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_EBREAK  = 3'd1;
	localparam logic [2:0] STAT_INVALID = 3'd2;
	localparam logic [2:0] STAT_FAULT   = 3'd3;
	localparam logic [2:0] STAT_HALTED  = 3'd4;

	// Item commands
	localparam logic CMD_EXEC  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE     = 1'd1;
	localparam logic [31:0] START_RESET = 32'h8000_0000;
	localparam logic [31:0] BASE_RESET  = 32'h8000_0000;

	// Opcodes
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

	// funct3 codes
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;
	localparam logic [2:0] F3_B   = 3'd0;
	localparam logic [2:0] F3_H   = 3'd1;
	localparam logic [2:0] F3_W   = 3'd2;
	localparam logic [2:0] F3_BU  = 3'd4;
	localparam logic [2:0] F3_HU  = 3'd5;
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR  = 3'd5;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_MUL = 3'd0;
	localparam logic [2:0] F3_DIV = 3'd4;
	localparam logic [2:0] F3_REM = 3'd6;

	// funct7 codes
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	localparam logic [4:0] REG_A0 = 5'd10;

endpackage

### design/rv32_if.sv
// ----------------------------------------------------------------------------
// rv32_if: channel interfaces of the execute core
// Input items (instruction or memory write) and result items, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface rv32_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] instruction;
	logic [15:0] load_offset;
	logic [31:0] load_word;

	modport source(output valid, command, instruction, load_offset, load_word,
		input ready);
	modport sink(input valid, command, instruction, load_offset, load_word,
		output ready);
endinterface

interface rv32_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] executed_pc;
	logic [31:0] next_pc;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic [31:0] trap_value;

	modport source(output valid, status, executed_pc, next_pc, dest_index,
		dest_value, trap_value, input ready);
	modport sink(input valid, status, executed_pc, next_pc, dest_index,
		dest_value, trap_value, output ready);
endinterface

### design/rv32_ctrl.sv
// ----------------------------------------------------------------------------
// rv32_ctrl: sequencing controller of the execute core
// Steps one item through register read, execute, memory or divide
// iterations and commit.
// ----------------------------------------------------------------------------
module rv32_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rv32_pkg::dp_stat_t   stat,
	output rv32_pkg::ctrl_cmd_t  cmd
);

	rv32_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rv32_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rv32_pkg::ST_IDLE: begin
				if (in_valid) state_nx = rv32_pkg::ST_READ;
			end
			rv32_pkg::ST_READ: state_nx = rv32_pkg::ST_EXEC;
			rv32_pkg::ST_EXEC: begin
				if (stat.go_mem)      state_nx = rv32_pkg::ST_MEM;
				else if (stat.go_div) state_nx = rv32_pkg::ST_DIV;
				else                  state_nx = rv32_pkg::ST_DONE;
			end
			rv32_pkg::ST_MEM: begin
				if (stat.mem_last) state_nx = rv32_pkg::ST_DONE;
			end
			rv32_pkg::ST_DIV: begin
				if (stat.div_last) state_nx = rv32_pkg::ST_DONE;
			end
			rv32_pkg::ST_DONE: begin
				if (!stat.out_busy) state_nx = rv32_pkg::ST_IDLE;
			end
			default: state_nx = rv32_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rv32_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_item = in_valid;
			end
			rv32_pkg::ST_READ: cmd.rf_read  = 1'b1;
			rv32_pkg::ST_EXEC: cmd.exec     = 1'b1;
			rv32_pkg::ST_MEM:  cmd.mem_step = 1'b1;
			rv32_pkg::ST_DIV:  cmd.div_step = 1'b1;
			rv32_pkg::ST_DONE: cmd.commit   = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

### design/rv32_dpath.sv
// ----------------------------------------------------------------------------
// rv32_dpath: datapath of the execute core
// Register file, pc, configuration, decode/ALU, byte data memory with a
// byte-per-cycle sequencer, radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module rv32_dpath #(
	parameter int unsigned DATA_BYTES = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rv32_pkg::ctrl_cmd_t              cmd,
	output rv32_pkg::dp_stat_t               stat,
	input  logic                             cfg_we,
	input  logic [rv32_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             in_command,
	input  logic [31:0]                      in_instruction,
	input  logic [15:0]                      in_load_offset,
	input  logic [31:0]                      in_load_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       out_status,
	output logic [31:0]                      out_executed_pc,
	output logic [31:0]                      out_next_pc,
	output logic [4:0]                       out_dest_index,
	output logic [31:0]                      out_dest_value,
	output logic [31:0]                      out_trap_value
);

	localparam int unsigned AW = $clog2(DATA_BYTES);
	localparam logic [32:0] DB_LIMIT = 33'(DATA_BYTES);

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	// Item, pc and configuration
	logic        cmd_q;
	logic [31:0] ins_q;
	logic [15:0] loff_q;
	logic [31:0] lword_q;
	logic [31:0] pc_q;
	logic [31:0] base_q;
	logic        halted_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			cmd_q   <= in_command;
			ins_q   <= in_instruction;
			loff_q  <= in_load_offset;
			lword_q <= in_load_word;
		end
	end

	// Register file with per-entry valid bits (reset reads zero)
	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] a_q, b_q;
	logic [4:0]  ra, rb;
	logic        rf_we;
	logic [4:0]  rd_q;
	logic        wr_q;

	assign ra = (ins_q == rv32_pkg::EBREAK_WORD) ? rv32_pkg::REG_A0 : ins_q[19:15];
	assign rb = ins_q[24:20];
	assign rf_we = cmd.commit && wr_q && (rd_q != 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.rf_read) begin
			a_q <= rf_vld_q[ra] ? rf_mem[ra] : 32'd0;
			b_q <= rf_vld_q[rb] ? rf_mem[rb] : 32'd0;
		end
	end

	// Decode and execute
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, addr_ls, off_ls;
	logic [2:0]  size_ls;
	logic        fit_ls, fit_wr;
	logic [2:0]  x_status;
	logic [31:0] x_npc, x_val, x_trap, x_wdata;
	logic        x_wr, x_mem, x_store, x_div, x_rem;
	logic [31:0] x_off;
	logic [2:0]  x_size;

	assign opc = ins_q[6:0];
	assign f3  = ins_q[14:12];
	assign f7  = ins_q[31:25];
	assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign imm_b = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign imm_j = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
	assign addr_ls = a_q + ((opc == rv32_pkg::OP_STORE) ? imm_s : imm_i);
	assign off_ls  = addr_ls - base_q;

	always_comb begin
		case (f3)
			rv32_pkg::F3_W:  size_ls = 3'd4;
			rv32_pkg::F3_H:  size_ls = 3'd2;
			rv32_pkg::F3_HU: size_ls = (opc == rv32_pkg::OP_LOAD) ? 3'd2 : 3'd0;
			rv32_pkg::F3_BU: size_ls = (opc == rv32_pkg::OP_LOAD) ? 3'd1 : 3'd0;
			rv32_pkg::F3_B:  size_ls = (opc == rv32_pkg::OP_STORE) ? 3'd1 : 3'd0;
			default:         size_ls = 3'd0;
		endcase
	end

	assign fit_ls = ({1'b0, off_ls} + 33'(size_ls)) <= DB_LIMIT;
	assign fit_wr = ({17'd0, loff_q} + 33'd4) <= DB_LIMIT;

	always_comb begin
		x_status = rv32_pkg::STAT_OK;
		x_npc    = pc_q + 32'd4;
		x_wr     = 1'b1;
		x_val    = 32'd0;
		x_trap   = 32'd0;
		x_mem    = 1'b0;
		x_store  = 1'b0;
		x_div    = 1'b0;
		x_rem    = 1'b0;
		x_off    = off_ls;
		x_size   = size_ls;
		x_wdata  = b_q;
		if (cmd_q == rv32_pkg::CMD_WRITE) begin
			x_npc   = pc_q;
			x_wr    = 1'b0;
			x_off   = {16'd0, loff_q};
			x_size  = 3'd4;
			x_wdata = lword_q;
			if (fit_wr) begin
				x_mem   = 1'b1;
				x_store = 1'b1;
			end else begin
				x_status = rv32_pkg::STAT_FAULT;
			end
		end else if (halted_q) begin
			x_status = rv32_pkg::STAT_HALTED;
			x_npc    = pc_q;
			x_wr     = 1'b0;
		end else begin
			unique case (opc)
				rv32_pkg::OP_LUI:   x_val = {ins_q[31:12], 12'd0};
				rv32_pkg::OP_AUIPC: x_val = pc_q + {ins_q[31:12], 12'd0};
				rv32_pkg::OP_JAL: begin
					x_val = pc_q + 32'd4;
					x_npc = pc_q + imm_j;
				end
				rv32_pkg::OP_JALR: begin
					if (f3 != 3'd0) x_status = rv32_pkg::STAT_INVALID;
					x_val = pc_q + 32'd4;
					x_npc = (a_q + imm_i) & ~32'd1;
				end
				rv32_pkg::OP_BRANCH: begin
					x_wr = 1'b0;
					case (f3)
						rv32_pkg::F3_BEQ: if (a_q == b_q) x_npc = pc_q + imm_b;
						rv32_pkg::F3_BNE: if (a_q != b_q) x_npc = pc_q + imm_b;
						rv32_pkg::F3_BLT:
							if ($signed(a_q) < $signed(b_q)) x_npc = pc_q + imm_b;
						rv32_pkg::F3_BGE:
							if (!($signed(a_q) < $signed(b_q))) x_npc = pc_q + imm_b;
						default: x_status = rv32_pkg::STAT_INVALID;
					endcase
				end
				rv32_pkg::OP_LOAD: begin
					if (size_ls == 3'd0)  x_status = rv32_pkg::STAT_INVALID;
					else if (!fit_ls)     x_status = rv32_pkg::STAT_FAULT;
					else                  x_mem = 1'b1;
				end
				rv32_pkg::OP_STORE: begin
					x_wr = 1'b0;
					if (size_ls == 3'd0)  x_status = rv32_pkg::STAT_INVALID;
					else if (!fit_ls)     x_status = rv32_pkg::STAT_FAULT;
					else begin
						x_mem   = 1'b1;
						x_store = 1'b1;
					end
				end
				rv32_pkg::OP_IMM: begin
					case (f3)
						rv32_pkg::F3_ADD:  x_val = a_q + imm_i;
						rv32_pkg::F3_AND:  x_val = a_q & imm_i;
						rv32_pkg::F3_XOR:  x_val = a_q ^ imm_i;
						rv32_pkg::F3_SLTU: x_val = {31'd0, a_q < imm_i};
						rv32_pkg::F3_SR: begin
							if (f7 == rv32_pkg::F7_ALT)
								x_val = 32'($signed(a_q) >>> ins_q[24:20]);
							else
								x_status = rv32_pkg::STAT_INVALID;
						end
						default: x_status = rv32_pkg::STAT_INVALID;
					endcase
				end
				rv32_pkg::OP_REG: begin
					if (f7 == rv32_pkg::F7_BASE) begin
						case (f3)
							rv32_pkg::F3_ADD:  x_val = a_q + b_q;
							rv32_pkg::F3_SLL:  x_val = a_q << b_q[4:0];
							rv32_pkg::F3_SLT:  x_val = {31'd0, $signed(a_q) < $signed(b_q)};
							rv32_pkg::F3_SLTU: x_val = {31'd0, a_q < b_q};
							rv32_pkg::F3_XOR:  x_val = a_q ^ b_q;
							rv32_pkg::F3_OR:   x_val = a_q | b_q;
							rv32_pkg::F3_AND:  x_val = a_q & b_q;
							default: x_status = rv32_pkg::STAT_INVALID;
						endcase
					end else if (f7 == rv32_pkg::F7_ALT && f3 == rv32_pkg::F3_ADD) begin
						x_val = a_q - b_q;
					end else if (f7 == rv32_pkg::F7_MULDIV && f3 == rv32_pkg::F3_MUL) begin
						x_val = a_q * b_q;
					end else if (f7 == rv32_pkg::F7_MULDIV &&
							(f3 == rv32_pkg::F3_DIV || f3 == rv32_pkg::F3_REM)) begin
						x_rem = (f3 == rv32_pkg::F3_REM);
						// Divide by zero is settled here without the divider
						if (b_q == 32'd0) x_val = x_rem ? a_q : 32'hFFFF_FFFF;
						else              x_div = 1'b1;
					end else begin
						x_status = rv32_pkg::STAT_INVALID;
					end
				end
				rv32_pkg::OP_SYSTEM: begin
					x_wr = 1'b0;
					if (ins_q == rv32_pkg::EBREAK_WORD) begin
						x_status = rv32_pkg::STAT_EBREAK;
						x_trap   = a_q;
					end else begin
						x_status = rv32_pkg::STAT_INVALID;
					end
				end
				default: x_status = rv32_pkg::STAT_INVALID;
			endcase
			if (x_status == rv32_pkg::STAT_INVALID || x_status == rv32_pkg::STAT_FAULT) begin
				x_npc = pc_q;
				x_wr  = 1'b0;
				x_mem = 1'b0;
				x_div = 1'b0;
			end
		end
	end

	// Execute result registers
	logic [2:0]  status_q;
	logic [31:0] npc_q, val_q, trap_q, epc_q, wdata_q, ld_q;
	logic        halt_set_q, load_q, lh_q, store_q;
	logic [AW-1:0] moff_q;
	logic [2:0]  msize_q, mcnt_q;
	logic [7:0]  rbyte_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= x_status;
			npc_q      <= x_npc;
			val_q      <= x_val;
			trap_q     <= x_trap;
			epc_q      <= pc_q;
			wr_q       <= x_wr;
			rd_q       <= ins_q[11:7];
			halt_set_q <= (cmd_q == rv32_pkg::CMD_EXEC) && (x_status != rv32_pkg::STAT_OK);
			load_q     <= x_mem && !x_store;
			lh_q       <= (f3 == rv32_pkg::F3_H);
			store_q    <= x_store;
			moff_q     <= x_off[AW-1:0];
			msize_q    <= x_size;
			wdata_q    <= x_wdata;
			mcnt_q     <= 3'd0;
			ld_q       <= 32'd0;
		end else if (cmd.mem_step) begin
			mcnt_q <= mcnt_q + 3'd1;
			if (!store_q && mcnt_q != 3'd0)
				ld_q[{mcnt_q[1:0] - 2'd1, 3'b000} +: 8] <= rbyte_q;
		end else if (cmd.div_step && stat.div_last) begin
			val_q <= div_res;
		end
	end

	// Data memory: one byte per cycle
	logic [7:0]    dmem [DATA_BYTES];
	logic [AW-1:0] maddr;
	logic [31:0]   wshift;

	assign maddr  = moff_q + AW'(mcnt_q);
	assign wshift = wdata_q >> {mcnt_q[1:0], 3'b000};

	always_ff @(posedge clk) begin
		if (cmd.mem_step && store_q)
			dmem[maddr] <= wshift[7:0];
		if (cmd.mem_step && !store_q && mcnt_q < msize_q)
			rbyte_q <= dmem[maddr];
	end

	// Restoring divider on magnitudes, one quotient bit per cycle
	logic [31:0] dq_q, dr_q, dv_q;
	logic [4:0]  dcnt_q;
	logic        dneg_q, drem_q;
	logic [32:0] r_sh, r_sub;
	logic        take;
	logic [31:0] r_nx, q_nx, d_sel, div_res;

	assign r_sh  = {dr_q, dq_q[31]};
	assign r_sub = r_sh - {1'b0, dv_q};
	assign take  = !r_sub[32];
	assign r_nx  = take ? r_sub[31:0] : r_sh[31:0];
	assign q_nx  = {dq_q[30:0], take};
	assign d_sel = drem_q ? r_nx : q_nx;
	assign div_res = dneg_q ? (32'd0 - d_sel) : d_sel;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			dq_q   <= mag32(a_q);
			dv_q   <= mag32(b_q);
			dr_q   <= 32'd0;
			dcnt_q <= 5'd0;
			drem_q <= x_rem;
			dneg_q <= x_rem ? a_q[31] : (a_q[31] ^ b_q[31]);
		end else if (cmd.div_step) begin
			dq_q   <= q_nx;
			dr_q   <= r_nx;
			dcnt_q <= dcnt_q + 5'd1;
		end
	end

	// Status to controller
	assign stat.go_mem   = x_mem;
	assign stat.go_div   = x_div;
	assign stat.mem_last = store_q ? (mcnt_q == msize_q - 3'd1) : (mcnt_q == msize_q);
	assign stat.div_last = (dcnt_q == 5'd31);
	assign stat.out_busy = out_valid && !out_ready;

	// Final value: loads assemble in ld_q
	logic [31:0] fin_val;
	assign fin_val = !load_q ? val_q :
		(lh_q ? {{16{ld_q[15]}}, ld_q[15:0]} : ld_q);

	// Register file write
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rd_q] <= fin_val;
	end

	// Control state: valid bits, pc, configuration, halt, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			pc_q      <= rv32_pkg::START_RESET;
			base_q    <= rv32_pkg::BASE_RESET;
			halted_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rf_we) rf_vld_q[rd_q] <= 1'b1;
			if (cfg_we && cfg_index == rv32_pkg::CFG_START_ADDRESS) pc_q <= cfg_data;
			if (cfg_we && cfg_index == rv32_pkg::CFG_DATA_BASE) base_q <= cfg_data;
			if (cmd.commit) begin
				pc_q <= npc_q;
				if (halt_set_q) halted_q <= 1'b1;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status      <= status_q;
			out_executed_pc <= epc_q;
			out_next_pc     <= npc_q;
			out_dest_index  <= (wr_q && rd_q != 5'd0) ? rd_q : 5'd0;
			out_dest_value  <= (wr_q && rd_q != 5'd0) ? fin_val : 32'd0;
			out_trap_value  <= trap_q;
		end
	end

endmodule

### design/rv32im_subset_execute_core.sv
// ----------------------------------------------------------------------------
// rv32im_subset_execute_core: multicycle RV32IM subset execute unit
// Executes one instruction word per transaction against its register file,
// pc and byte data memory, or writes one word into data memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     command, instruction, load_offset, load_word
//  out_ch    out  valid/ready     status, executed_pc, next_pc, dest_index,
//                                 dest_value, trap_value
//  cfg       in   cfg_we          cfg_index, cfg_data
//
// Most instructions step through accept, register read, execute and commit;
// loads and stores add byte steps in the byte-wide memory port, and div/rem
// add divide steps in the radix-2 divider. One transaction is worked at a time.
// Reset clears register valid bits and halt flag; pc and data base take reset values.
// A result waiting on out_ch holds the next transaction at commit only.
module rv32im_subset_execute_core #(
	parameter int unsigned DATA_BYTES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rv32_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	rv32_in_if.sink                        in_ch,
	rv32_out_if.source                     out_ch
);

	rv32_pkg::ctrl_cmd_t cmd;
	rv32_pkg::dp_stat_t  stat;

	rv32_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rv32_dpath #(
		.DATA_BYTES (DATA_BYTES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_command      (in_ch.command),
		.in_instruction  (in_ch.instruction),
		.in_load_offset  (in_ch.load_offset),
		.in_load_word    (in_ch.load_word),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_status      (out_ch.status),
		.out_executed_pc (out_ch.executed_pc),
		.out_next_pc     (out_ch.next_pc),
		.out_dest_index  (out_ch.dest_index),
		.out_dest_value  (out_ch.dest_value),
		.out_trap_value  (out_ch.trap_value)
	);

endmodule

### bench/rv32im_subset_execute_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32im_subset_execute_core_tb: self-checking bench of the execute core
// Feeds memory-write and instruction transactions, keeps its own copy of the
// architectural state to predict each result, and compares every result
// transaction field by field. Handshake idling varies over three phases.
// ----------------------------------------------------------------------------
module rv32im_subset_execute_core_tb;
	import rv32_pkg::*;

	typedef struct packed {
		logic        command;
		logic [31:0] instruction;
		logic [15:0] load_offset;
		logic [31:0] load_word;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] executed_pc;
		logic [31:0] next_pc;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic [31:0] trap_value;
	} res_t;

	localparam int unsigned MEM_BYTES = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	rv32_in_if in_ch();
	rv32_out_if out_ch();

	rv32im_subset_execute_core #(.DATA_BYTES(MEM_BYTES)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// Predicted architectural state
	logic [31:0] m_start, m_base, m_pc;
	logic [31:0] m_regs [32];
	logic [7:0]  m_mem [MEM_BYTES];
	bit          m_written [MEM_BYTES];
	logic        m_halted;

	item_t pending_items[$];
	res_t  expected_results[$];
	int    errors = 0;
	int    send_idle = 0, recv_idle = 0;
	bit    done_sending = 0;

	// Generator-side shadow of written bytes; it is set but never read
	bit    gen_written [MEM_BYTES];

	function automatic logic [31:0] sx(logic [31:0] v, int bits);
		logic [31:0] r;
		r = v & ((32'd1 << bits) - 1);
		if (r[bits-1]) r = r | ~((32'd1 << bits) - 1);
		return r;
	endfunction

	function automatic logic window_ok(logic [31:0] off, int size);
		return ({32'd0, off} + size) <= MEM_BYTES;
	endfunction

	// Compute the expected result of one transaction and update the state
	function automatic res_t execute_predict(item_t it);
		res_t r;
		logic [31:0] ins, a, b, immI, immS, immB, immJ, addr, off, val, npc, q, ma, mb;
		logic [6:0] op, f7;
		logic [2:0] f3, st;
		logic [4:0] rd;
		logic wr;
		int size;
		ins = it.instruction;
		r = '0;
		r.executed_pc = m_pc;
		r.next_pc = m_pc;
		if (it.command == CMD_WRITE) begin
			if (window_ok({16'd0, it.load_offset}, 4)) begin
				for (int k = 0; k < 4; k++) begin
					m_mem[it.load_offset + k] = it.load_word[8*k +: 8];
					m_written[it.load_offset + k] = 1;
				end
			end else
				r.status = STAT_FAULT;
			return r;
		end
		if (m_halted) begin
			r.status = STAT_HALTED;
			return r;
		end
		op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
		a = m_regs[ins[19:15]]; b = m_regs[ins[24:20]];
		immI = sx(ins >> 20, 12);
		immS = sx({ins[31:25], ins[11:7]}, 12);
		immB = sx({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
		immJ = sx({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
		npc = m_pc + 4; wr = 1; val = 0; st = STAT_OK;
		case (op)
			OP_LUI: val = {ins[31:12], 12'd0};
			OP_AUIPC: val = m_pc + {ins[31:12], 12'd0};
			OP_JAL: begin val = m_pc + 4; npc = m_pc + immJ; end
			OP_JALR: begin
				if (f3 != 3'd0) st = STAT_INVALID;
				else begin val = m_pc + 4; npc = (a + immI) & ~32'd1; end
			end
			OP_BRANCH: begin
				wr = 0;
				case (f3)
					F3_BEQ: if (a == b) npc = m_pc + immB;
					F3_BNE: if (a != b) npc = m_pc + immB;
					F3_BLT: if ($signed(a) < $signed(b)) npc = m_pc + immB;
					F3_BGE: if (!($signed(a) < $signed(b))) npc = m_pc + immB;
					default: st = STAT_INVALID;
				endcase
			end
			OP_LOAD: begin
				size = (f3 == F3_W) ? 4 : (f3 == F3_H || f3 == F3_HU) ? 2 :
					(f3 == F3_BU) ? 1 : 0;
				if (size == 0) st = STAT_INVALID;
				else begin
					off = a + immI - m_base;
					if (!window_ok(off, size)) st = STAT_FAULT;
					else begin
						for (int k = 0; k < size; k++)
							val[8*k +: 8] = m_mem[off + k];
						if (f3 == F3_H) val = sx(val, 16);
					end
				end
			end
			OP_STORE: begin
				wr = 0;
				size = (f3 == F3_W) ? 4 : (f3 == F3_H) ? 2 : (f3 == F3_B) ? 1 : 0;
				if (size == 0) st = STAT_INVALID;
				else begin
					off = a + immS - m_base;
					if (!window_ok(off, size)) st = STAT_FAULT;
					else for (int k = 0; k < size; k++) begin
						m_mem[off + k] = b[8*k +: 8];
						m_written[off + k] = 1;
					end
				end
			end
			OP_IMM: begin
				if (f3 == F3_ADD) val = a + immI;
				else if (f3 == F3_AND) val = a & immI;
				else if (f3 == F3_XOR) val = a ^ immI;
				else if (f3 == F3_SLTU) val = (a < immI) ? 32'd1 : 32'd0;
				else if (f3 == F3_SR && f7 == F7_ALT) val = $signed(a) >>> ins[24:20];
				else st = STAT_INVALID;
			end
			OP_REG: begin
				ma = a[31] ? -a : a; mb = b[31] ? -b : b;
				if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD: val = a + b;
						F3_SLL: val = a << b[4:0];
						F3_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
						F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
						F3_XOR: val = a ^ b;
						F3_OR: val = a | b;
						F3_AND: val = a & b;
						default: st = STAT_INVALID;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
				else if (f7 == F7_MULDIV && f3 == F3_MUL) val = a * b;
				else if (f7 == F7_MULDIV && f3 == F3_DIV) begin
					if (b == 0) val = '1;
					else begin q = ma / mb; val = (a[31] ^ b[31]) ? -q : q; end
				end else if (f7 == F7_MULDIV && f3 == F3_REM) begin
					if (b == 0) val = a;
					else begin q = ma % mb; val = a[31] ? -q : q; end
				end else st = STAT_INVALID;
			end
			OP_SYSTEM: begin
				wr = 0;
				if (ins == EBREAK_WORD) begin
					st = STAT_EBREAK; r.trap_value = m_regs[REG_A0];
				end else st = STAT_INVALID;
			end
			default: st = STAT_INVALID;
		endcase
		if (st == STAT_INVALID || st == STAT_FAULT) begin
			npc = m_pc; wr = 0;
		end
		if (st != STAT_OK) m_halted = 1;
		if (wr && rd != 0) begin
			m_regs[rd] = val;
			r.dest_index = rd;
			r.dest_value = val;
		end
		m_pc = npc;
		r.status = st;
		r.next_pc = npc;
		return r;
	endfunction

	// Driver: presents queued items, idles at random, changes on falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					item_t it;
					it = pending_items.pop_front();
					expected_results.push_back(execute_predict(it));
					in_ch.valid <= 1'b1;
					in_ch.command <= it.command;
					in_ch.instruction <= it.instruction;
					in_ch.load_offset <= it.load_offset;
					in_ch.load_word <= it.load_word;
				end else
					in_ch.valid <= 1'b0;
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Track acceptance on the rising edge (valid held until ready seen)
	logic in_fire;
	always @(posedge clk) in_fire <= in_ch.valid && in_ch.ready;

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			res_t got, exp_r;
			got = {out_ch.status, out_ch.executed_pc, out_ch.next_pc,
				out_ch.dest_index, out_ch.dest_value, out_ch.trap_value};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.status !== exp_r.status)
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, got.status);
				if (got.executed_pc !== exp_r.executed_pc)
					$display("%0t: executed_pc expected %h actual %h", $time,
						exp_r.executed_pc, got.executed_pc);
				if (got.next_pc !== exp_r.next_pc)
					$display("%0t: next_pc expected %h actual %h", $time,
						exp_r.next_pc, got.next_pc);
				if (got.dest_index !== exp_r.dest_index)
					$display("%0t: dest_index expected %0d actual %0d", $time,
						exp_r.dest_index, got.dest_index);
				if (got.dest_value !== exp_r.dest_value)
					$display("%0t: dest_value expected %h actual %h", $time,
						exp_r.dest_value, got.dest_value);
				if (got.trap_value !== exp_r.trap_value)
					$display("%0t: trap_value expected %h actual %h", $time,
						exp_r.trap_value, got.trap_value);
				if (got !== exp_r) errors++;
			end
		end
	end

	// Encoders
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction
	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction
	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction
	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	task automatic push_exec(logic [31:0] ins);
		item_t it;
		it = '0;
		it.command = CMD_EXEC;
		it.instruction = ins;
		it.load_offset = $urandom;
		it.load_word = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic push_write(logic [15:0] off, logic [31:0] w);
		item_t it;
		it.command = CMD_WRITE;
		it.instruction = $urandom;
		it.load_offset = off;
		it.load_word = w;
		pending_items.push_back(it);
		if ({16'd0, off} + 4 <= MEM_BYTES)
			for (int k = 0; k < 4; k++) gen_written[off + k] = 1;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START_ADDRESS) begin m_start = v; m_pc = v; end
		else m_base = v;
	endtask

	// Does not reset the halt state: the core and the model stay halted, so
	// a new program phase continues with halted items tested too.
	task automatic gen_program(int count, logic [31:0] base);
		logic [4:0] rd, rs1, rs2;
		logic [31:0] r;
		int kind;
		logic [15:0] off;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			rd = $urandom; rs1 = $urandom_range(0, 7); rs2 = $urandom_range(0, 7);
			if (kind < 20) begin
				// well-formed ALU immediate op, LUI or AUIPC
				case ($urandom_range(9))
					0: push_exec(enc_i($urandom, rs1, F3_ADD, rd[2:0], OP_IMM));
					1: push_exec(enc_i($urandom, rs1, F3_AND, rd, OP_IMM));
					2: push_exec(enc_i($urandom, rs1, F3_XOR, rd, OP_IMM));
					3: push_exec(enc_i($urandom, rs1, F3_SLTU, rd, OP_IMM));
					4: push_exec(enc_i({7'h20, 5'($urandom)}, rs1, F3_SR, rd, OP_IMM));
					5: push_exec({20'($urandom), rd, OP_LUI});
					6: push_exec({20'($urandom), rd, OP_AUIPC});
					default: push_exec(enc_i($urandom, 5'd0, F3_ADD, rd[2:0], OP_IMM));
				endcase
			end else if (kind < 50) begin
				r = $urandom_range(10);
				case (r)
					0: push_exec(enc_r(F7_BASE, rs2, rs1, F3_ADD, rd, OP_REG));
					1: push_exec(enc_r(F7_BASE, rs2, rs1, F3_SLL, rd, OP_REG));
					2: push_exec(enc_r(F7_BASE, rs2, rs1, F3_SLT, rd, OP_REG));
					3: push_exec(enc_r(F7_BASE, rs2, rs1, F3_SLTU, rd, OP_REG));
					4: push_exec(enc_r(F7_BASE, rs2, rs1, F3_XOR, rd, OP_REG));
					5: push_exec(enc_r(F7_BASE, rs2, rs1, F3_OR, rd, OP_REG));
					6: push_exec(enc_r(F7_BASE, rs2, rs1, F3_AND, rd, OP_REG));
					7: push_exec(enc_r(F7_ALT, rs2, rs1, F3_ADD, rd, OP_REG));
					8: push_exec(enc_r(F7_MULDIV, rs2, rs1, F3_MUL, rd, OP_REG));
					9: push_exec(enc_r(F7_MULDIV, rs2, rs1, F3_DIV, rd, OP_REG));
					default: push_exec(enc_r(F7_MULDIV, rs2, rs1, F3_REM, rd, OP_REG));
				endcase
			end else if (kind < 62) begin
				// store into the window, addressed from x31, which holds the data base
				off = $urandom_range(0, 2040);
				case ($urandom_range(2))
					0: push_exec(enc_s(off[11:0], rs2, 5'd31, F3_W));
					1: push_exec(enc_s(off[11:0], rs2, 5'd31, F3_H));
					default: push_exec(enc_s(off[11:0], rs2, 5'd31, F3_B));
				endcase
				for (int k = 0; k < 4; k++) gen_written[off + k] = 1;
			end else if (kind < 74) begin
				// load from bytes already written (first 2 KiB, seeded below)
				off = $urandom_range(0, 2040);
				case ($urandom_range(3))
					0: push_exec(enc_i(off[11:0], 5'd31, F3_W, rd, OP_LOAD));
					1: push_exec(enc_i(off[11:0], 5'd31, F3_H, rd, OP_LOAD));
					2: push_exec(enc_i(off[11:0], 5'd31, F3_HU, rd, OP_LOAD));
					default: push_exec(enc_i(off[11:0], 5'd31, F3_BU, rd, OP_LOAD));
				endcase
			end else if (kind < 86) begin
				r = $urandom_range(3);
				push_exec(enc_b(13'($urandom), rs2, rs1,
					(r == 0) ? F3_BEQ : (r == 1) ? F3_BNE : (r == 2) ? F3_BLT : F3_BGE));
			end else if (kind < 92) begin
				if ($urandom_range(1)) push_exec({21'($urandom), rd, OP_JAL});
				else push_exec(enc_i($urandom, rs1, 3'd0, rd, OP_JALR));
			end else if (kind < 96) begin
				push_write($urandom_range(0, 2044), $urandom);
			end else
				push_write($urandom_range(65533, 65535), $urandom);
		end
	endtask

	// Fill the first 2 KiB, set x31 to the data base (lui+addi) and x1 to x7 at random
	task automatic prime_state(logic [31:0] base);
		logic [31:0] hi;
		for (int o = 0; o < 2048; o += 4) push_write(o[15:0], $urandom);
		hi = base + 32'h800;
		push_exec({hi[31:12], 5'd31, OP_LUI});
		push_exec(enc_i(base[11:0], 5'd31, F3_ADD, 5'd31, OP_IMM));
		for (int k = 1; k < 8; k++) push_exec({20'($urandom), 5'(k), OP_LUI});
		for (int k = 1; k < 8; k++)
			push_exec(enc_i($urandom, 5'(k), F3_XOR, 5'(k), OP_IMM));
	endtask

	// Run the directed part and three random phases; a halt ends useful execution,
	// and reloading start_address moves the pc but does not clear the halt.
	initial begin
		in_ch.valid = 1'b0; in_ch.command = CMD_EXEC; in_ch.instruction = '0;
		in_ch.load_offset = '0; in_ch.load_word = '0;
		out_ch.ready = 1'b0;
		m_start = START_RESET; m_base = BASE_RESET; m_pc = START_RESET; m_halted = 0;
		for (int k = 0; k < 32; k++) m_regs[k] = '0;
		for (int k = 0; k < MEM_BYTES; k++) begin m_mem[k] = '0; m_written[k] = 0; end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part
		send_idle = 13; recv_idle = 83;
		prime_state(BASE_RESET);
		push_write(16'hFFFC, 32'hFFFF_FFFF);
		push_write(16'hFFFD, 32'h1234_5678);
		push_exec(enc_i(12'h7FF, 5'd1, F3_ADD, 5'd10, OP_IMM));
		push_exec(enc_i(12'h800, 5'd0, F3_ADD, 5'd8, OP_IMM));
		push_exec({12'h0, 5'd8, 3'd0, 5'd9, OP_LUI} | 32'h8000_0000);
		push_exec(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd11, OP_IMM));
		push_exec(enc_r(F7_MULDIV, 5'd11, 5'd9, F3_DIV, 5'd12, OP_REG));
		push_exec(enc_r(F7_MULDIV, 5'd11, 5'd9, F3_REM, 5'd13, OP_REG));
		push_exec(enc_r(F7_MULDIV, 5'd0, 5'd9, F3_DIV, 5'd14, OP_REG));
		push_exec(enc_r(F7_MULDIV, 5'd0, 5'd9, F3_REM, 5'd15, OP_REG));
		push_exec(enc_i({7'h20, 5'd31}, 5'd9, F3_SR, 5'd16, OP_IMM));
		push_exec(enc_r(F7_BASE, 5'd11, 5'd9, F3_SLL, 5'd17, OP_REG));
		push_exec(enc_i(12'hFFF, 5'd31, F3_W, 5'd0, OP_LOAD));
		push_exec(enc_i(12'h7FF, 5'd31, F3_H, 5'd18, OP_LOAD));
		push_exec(enc_i(12'd0, 5'd8, 3'd1, 5'd1, OP_JALR));
		push_exec(EBREAK_WORD);
		push_exec(32'hFFFF_FFFF);
		wait_drained();

		// Random phases; each ends halted, so the start address re-arms the pc
		// but the halted flag stays, exercising halted responses afterwards.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 0) begin send_idle = 13; recv_idle = 83; end
			else if (ph == 1) begin send_idle = 83; recv_idle = 13; end
			else begin send_idle = 0; recv_idle = 0; end
			write_cfg(CFG_DATA_BASE, (ph == 1) ? 32'hFFFF_0000 : (ph == 2) ? 32'h0 : 32'h1000);
			write_cfg(CFG_START_ADDRESS, (ph == 2) ? 32'hFFFF_FFFC : $urandom);
			prime_state(m_base);
			gen_program(300, m_base);
			wait_drained();
		end
		done_sending = 1;
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### files.f
design/rv32_pkg.sv
design/rv32_if.sv
design/rv32_ctrl.sv
design/rv32_dpath.sv
design/rv32im_subset_execute_core.sv
bench/rv32im_subset_execute_core_tb.sv
